FILE: design/silp_pkg.sv
// ----------------------------------------------------------------------------
// silp_pkg
// Shared widths, character codes, phase and radix types and digit helper
// functions for the signed integer literal parser.
// ----------------------------------------------------------------------------
package silp_pkg;

   localparam int WIDTH = 16;
   // product of accumulator and base (up to x16) plus one digit
   localparam int SUM_W = WIDTH + 5;

   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_UNDER = 8'h5F;
   localparam logic [7:0] CH_LC_X  = 8'h78;
   localparam logic [7:0] CH_UC_X  = 8'h58;
   localparam logic [7:0] CH_LC_O  = 8'h6F;
   localparam logic [7:0] CH_UC_O  = 8'h4F;
   localparam logic [7:0] CH_LC_B  = 8'h62;
   localparam logic [7:0] CH_UC_B  = 8'h42;
   localparam logic [7:0] CH_LC_U  = 8'h75;
   localparam logic [7:0] CH_UC_U  = 8'h55;

   localparam logic [4:0] NO_DIGIT = 5'd16;

   typedef enum logic [4:0] {
      PH_START       = 5'b00001,
      PH_AFTER_SIGN  = 5'b00010,
      PH_ZERO_SEEN   = 5'b00100,
      PH_FIRST_DIGIT = 5'b01000,
      PH_DIGITS      = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      RADIX_DEC = 2'd0,
      RADIX_HEX = 2'd1,
      RADIX_OCT = 2'd2,
      RADIX_BIN = 2'd3
   } radix_type;

   // value of a hex digit character, NO_DIGIT for anything else
   function automatic logic [4:0] digit_value(input logic [7:0] c);
      logic [4:0] v;
      v = NO_DIGIT;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 5'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = 5'(c - 8'h61 + 8'd10);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 5'(c - 8'h41 + 8'd10);
      end
      return v;
   endfunction

   function automatic logic [4:0] radix_base(input radix_type r);
      logic [4:0] b;
      case (r)
         RADIX_DEC: b = 5'd10;
         RADIX_HEX: b = 5'd16;
         RADIX_OCT: b = 5'd8;
         RADIX_BIN: b = 5'd2;
         default:   b = 5'd10;
      endcase
      return b;
   endfunction

endpackage

FILE: design/silp_channels.sv
// ----------------------------------------------------------------------------
// silp channels
// Valid/ready channels for characters in and parse results out.
// ----------------------------------------------------------------------------
interface silp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       is_last;

   modport source (output valid, output char_code, output is_last, input ready);
   modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface silp_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [silp_pkg::WIDTH-1:0]  parsed_value;
   logic                               parse_error;

   modport source (output valid, output parsed_value, output parse_error, input ready);
   modport sink   (input valid, input parsed_value, input parse_error, output ready);
endinterface

FILE: design/signed_integer_literal_parser.sv
// ----------------------------------------------------------------------------
// signed_integer_literal_parser
// Parses a signed integer literal with optional sign and radix prefix,
// one character per beat, and returns value and error flag on the last one.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                        | beat
//  req_ch   | in  | char_code[7:0], is_last        | one character
//  rsp_ch   | out | parsed_value[15:0], parse_error| one result per string
//
// one character per cycle while req_ch.ready is high; a result shows on
// rsp_ch the cycle after the last character is taken. parse state and
// result register are the only storage, the update is one shift-add and
// compare. req_ch.ready drops only while a result is held and rsp_ch.ready
// is low. reset clears the parse state and the result valid.
module signed_integer_literal_parser (
   input  logic              clock,
   input  logic              reset,
   silp_req_if.sink          req_ch,
   silp_rsp_if.source        rsp_ch
);

   silp_pkg::phase_type          phase_ff, phase_in;
   silp_pkg::radix_type          radix_ff, radix_in;
   logic                         neg_ff, neg_in;
   logic                         stop_ff, stop_in;
   logic [silp_pkg::WIDTH-1:0]   acc_ff, acc_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [silp_pkg::WIDTH-1:0]   value_ff, value_in;
   logic                         error_ff, error_in;

   logic                         accept;
   logic [7:0]                   c;
   logic [4:0]                   dval;
   logic                         dig_ok;
   logic [silp_pkg::SUM_W-1:0]   acc_x;
   logic [silp_pkg::SUM_W-1:0]   prod;
   logic [silp_pkg::SUM_W-1:0]   total;
   logic [silp_pkg::SUM_W-1:0]   limit;
   logic                         ovf;
   logic                         ok;

   assign accept = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign c = req_ch.char_code;

   assign dval   = silp_pkg::digit_value(c);
   assign dig_ok = dval < silp_pkg::radix_base(radix_ff);
   assign acc_x  = silp_pkg::SUM_W'(acc_ff);

   always_comb begin
      case (radix_ff)
         silp_pkg::RADIX_DEC: prod = (acc_x << 3) + (acc_x << 1);
         silp_pkg::RADIX_HEX: prod = acc_x << 4;
         silp_pkg::RADIX_OCT: prod = acc_x << 3;
         silp_pkg::RADIX_BIN: prod = acc_x << 1;
         default:             prod = acc_x;
      endcase
   end

   // acc*base + d > limit is the same test as acc > (limit - d) / base
   assign total = prod + silp_pkg::SUM_W'(dval);
   assign limit = (silp_pkg::SUM_W'(1) << (silp_pkg::WIDTH - 1))
                  - silp_pkg::SUM_W'(!neg_ff);
   assign ovf   = total > limit;

   always_comb begin
      phase_in = phase_ff;
      radix_in = radix_ff;
      neg_in   = neg_ff;
      stop_in  = stop_ff;
      acc_in   = acc_ff;
      if (!stop_ff) begin
         case (phase_ff)
            silp_pkg::PH_START, silp_pkg::PH_AFTER_SIGN: begin
               if (phase_ff == silp_pkg::PH_START && c == silp_pkg::CH_MINUS) begin
                  neg_in   = 1'b1;
                  phase_in = silp_pkg::PH_AFTER_SIGN;
               end else if (phase_ff == silp_pkg::PH_START && c == silp_pkg::CH_PLUS) begin
                  phase_in = silp_pkg::PH_AFTER_SIGN;
               end else if (c == silp_pkg::CH_ZERO) begin
                  acc_in   = '0;
                  phase_in = silp_pkg::PH_ZERO_SEEN;
               end else begin
                  // radix is still decimal here
                  radix_in = silp_pkg::RADIX_DEC;
                  if (!dig_ok) begin
                     stop_in = 1'b1;
                  end else begin
                     acc_in   = silp_pkg::WIDTH'(dval);
                     phase_in = silp_pkg::PH_DIGITS;
                  end
               end
            end
            silp_pkg::PH_ZERO_SEEN: begin
               if (c == silp_pkg::CH_LC_X || c == silp_pkg::CH_UC_X) begin
                  radix_in = silp_pkg::RADIX_HEX;
                  phase_in = silp_pkg::PH_FIRST_DIGIT;
               end else if (c == silp_pkg::CH_LC_O || c == silp_pkg::CH_UC_O) begin
                  radix_in = silp_pkg::RADIX_OCT;
                  phase_in = silp_pkg::PH_FIRST_DIGIT;
               end else if (c == silp_pkg::CH_LC_B || c == silp_pkg::CH_UC_B) begin
                  radix_in = silp_pkg::RADIX_BIN;
                  phase_in = silp_pkg::PH_FIRST_DIGIT;
               end else if (c == silp_pkg::CH_LC_U || c == silp_pkg::CH_UC_U) begin
                  radix_in = silp_pkg::RADIX_DEC;
                  phase_in = silp_pkg::PH_FIRST_DIGIT;
               end else begin
                  // the zero was the first digit, accumulator already zero
                  phase_in = silp_pkg::PH_DIGITS;
                  if (c != silp_pkg::CH_UNDER) begin
                     if (!dig_ok || ovf) begin
                        stop_in = 1'b1;
                     end else begin
                        acc_in = total[silp_pkg::WIDTH-1:0];
                     end
                  end
               end
            end
            silp_pkg::PH_FIRST_DIGIT: begin
               if (!dig_ok) begin
                  stop_in = 1'b1;
               end else begin
                  acc_in   = silp_pkg::WIDTH'(dval);
                  phase_in = silp_pkg::PH_DIGITS;
               end
            end
            silp_pkg::PH_DIGITS: begin
               if (c != silp_pkg::CH_UNDER) begin
                  if (!dig_ok || ovf) begin
                     stop_in = 1'b1;
                  end else begin
                     acc_in = total[silp_pkg::WIDTH-1:0];
                  end
               end
            end
            default: begin
               stop_in = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      ok = !stop_in && (phase_in == silp_pkg::PH_DIGITS || phase_in == silp_pkg::PH_ZERO_SEEN);
      value_in = '0;
      if (ok) begin
         value_in = neg_in ? (silp_pkg::WIDTH'(0) - acc_in) : acc_in;
      end
      error_in = !ok;

      rsp_valid_in = rsp_valid_ff;
      if (accept && req_ch.is_last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= silp_pkg::PH_START;
         radix_ff     <= silp_pkg::RADIX_DEC;
         neg_ff       <= 1'b0;
         stop_ff      <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            if (req_ch.is_last) begin
               // string done, back to the start state
               phase_ff <= silp_pkg::PH_START;
               radix_ff <= silp_pkg::RADIX_DEC;
               neg_ff   <= 1'b0;
               stop_ff  <= 1'b0;
               acc_ff   <= '0;
            end else begin
               phase_ff <= phase_in;
               radix_ff <= radix_in;
               neg_ff   <= neg_in;
               stop_ff  <= stop_in;
               acc_ff   <= acc_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_ch.is_last) begin
         value_ff <= value_in;
         error_ff <= error_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.parsed_value = value_ff;
   assign rsp_ch.parse_error  = error_ff;

endmodule
